// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified assertion shorthands for the lock manager.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert a property on every rising clock edge outside reset
`define MLTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// assert that an expression never holds
`define MLTF_NEVER(lbl, expr, msg) \
  `MLTF_ASSERT(lbl, !(expr), msg)

`endif

// File: hw/rtl/mltf_pkg.sv
// ----------------------------------------------------------------------------
// mltf_pkg
// Shared codes and controller/datapath interface types of the lock manager.
// ----------------------------------------------------------------------------
package mltf_pkg;

  localparam int NUM_LOCKS = 64;
  localparam int NUM_PROCS = 256;

  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_ACQUIRE = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_BLOCKED  = 3'd1,
    STAT_NOLOCK   = 3'd2,
    STAT_NOTOWNER = 3'd3,
    STAT_FULL     = 3'd4
  } status_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic fetch;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic need_fetch;
    logic res_busy;
  } sts_t;

endpackage

// File: hw/rtl/mutex_lock_table_with_fifo_waiters.sv
// ----------------------------------------------------------------------------
// mutex_lock_table_with_fifo_waiters
// Lock manager: create, acquire and release of locks with FIFO hand-off.
// ----------------------------------------------------------------------------
// After reset the block sweeps its per-process wait table, one entry a cycle,
// with in_ready_o low until the sweep is done. From then on it takes one
// request at a time: accept reads the lock and wait table entries, and the
// commit decides and writes them back; a release that hands the lock to a
// waiter with further waiters behind it needs one more read of the waiter
// link table in between. The result beat sits in an output register, so the
// next request is accepted while it waits for out_ready_i; a second result
// waits until the first is taken.
module mutex_lock_table_with_fifo_waiters (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [5:0] lock_id_i,
  input  logic [7:0] proc_id_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic [5:0] new_lock_id_o,
  output logic       woken_valid_o,
  output logic [7:0] woken_proc_o
);
  import mltf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mltf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mltf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (opcode_i),
    .lock_id_i     (lock_id_i),
    .proc_id_i     (proc_id_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .new_lock_id_o (new_lock_id_o),
    .woken_valid_o (woken_valid_o),
    .woken_proc_o  (woken_proc_o)
  );

endmodule

// File: hw/rtl/mltf_ctrl.sv
// ----------------------------------------------------------------------------
// mltf_ctrl
// Sequencer of the lock manager: memory clear, request load, execute,
// waiter-link fetch and commit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mltf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mltf_pkg::sts_t sts_i,
  output mltf_pkg::cmd_t cmd_o
);
  import mltf_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_LINK  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.need_fetch) begin
          cmd_o.fetch = 1'b1;
          state_d     = S_LINK;
        end else if (!sts_i.res_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_LINK: begin
        if (!sts_i.res_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `MLTF_NEVER(a_fetch_commit, cmd_o.fetch && cmd_o.commit, "fetch and commit together")
  `MLTF_NEVER(a_accept_in_clear, cmd_o.clear && in_ready_o, "ready during memory clear")
  `MLTF_ASSERT(a_link_after_fetch, state_q == S_LINK |-> $past(cmd_o.fetch) || $past(state_q == S_LINK), "link state without fetch")

endmodule

// File: hw/rtl/mltf_dp.sv
// ----------------------------------------------------------------------------
// mltf_dp
// Datapath of the lock manager: lock table, wait table, waiter links,
// request decode and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mltf_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mltf_pkg::cmd_t cmd_i,
  output mltf_pkg::sts_t sts_o,
  input  logic [1:0]     opcode_i,
  input  logic [5:0]     lock_id_i,
  input  logic [7:0]     proc_id_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [2:0]     status_o,
  output logic [5:0]     new_lock_id_o,
  output logic           woken_valid_o,
  output logic [7:0]     woken_proc_o
);
  import mltf_pkg::*;

  localparam int LW = $clog2(NUM_LOCKS);
  localparam int PW = $clog2(NUM_PROCS);
  localparam int CW = $clog2(NUM_LOCKS + 1);

  typedef struct packed {
    logic          claimed;
    logic [PW-1:0] owner;
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
    logic          nonempty;
  } lock_ent_t;

  typedef struct packed {
    logic          busy;
    logic [LW-1:0] lock;
  } wait_ent_t;

  lock_ent_t     lock_mem [NUM_LOCKS];
  wait_ent_t     wait_mem [NUM_PROCS];
  logic [PW-1:0] next_mem [NUM_PROCS];

  logic [1:0]    op_q;
  logic [5:0]    lid_q;
  logic [7:0]    pid_q;
  lock_ent_t     lk_q;
  wait_ent_t     wt_q;
  logic [PW-1:0] nx_q;
  logic [CW-1:0] free_q;
  logic [PW-1:0] clr_q;

  logic          out_valid_q;
  status_e       status_q;
  logic [5:0]    nid_q;
  logic          woken_q;
  logic [7:0]    wproc_q;

  logic [LW-1:0] l_idx;
  logic [PW-1:0] p_idx;
  logic          lock_ok, proc_ok;

  status_e       res_st;
  logic [5:0]    res_nid;
  logic          res_wv;
  logic [PW-1:0] res_wp;
  logic          free_inc;
  logic          need_fetch;
  logic          lk_we;
  logic [LW-1:0] lk_wa;
  lock_ent_t     lk_wd;
  logic          wt_we;
  logic [PW-1:0] wt_wa;
  wait_ent_t     wt_wd;
  logic          nx_we;
  logic [PW-1:0] nx_wa;
  logic [PW-1:0] nx_wd;

  assign l_idx   = LW'(lid_q);
  assign p_idx   = PW'(pid_q);
  assign lock_ok = 32'(lid_q) < 32'(free_q);
  assign proc_ok = 32'(pid_q) < NUM_PROCS;

  always_comb begin
    res_st     = STAT_OK;
    res_nid    = '0;
    res_wv     = 1'b0;
    res_wp     = '0;
    free_inc   = 1'b0;
    need_fetch = 1'b0;
    lk_we      = 1'b0;
    lk_wa      = l_idx;
    lk_wd      = lk_q;
    wt_we      = 1'b0;
    wt_wa      = p_idx;
    wt_wd      = '{busy: 1'b1, lock: l_idx};
    nx_we      = 1'b0;
    nx_wa      = lk_q.tail;
    nx_wd      = p_idx;
    case (op_q)
      OP_CREATE: begin
        if (free_q == CW'(NUM_LOCKS)) begin
          res_st = STAT_FULL;
        end else begin
          lk_we    = 1'b1;
          lk_wa    = LW'(free_q);
          lk_wd    = '0;
          res_nid  = 6'(free_q);
          free_inc = 1'b1;
        end
      end
      OP_ACQUIRE: begin
        if (!lock_ok) begin
          res_st = STAT_NOLOCK;
        end else if (!proc_ok) begin
          res_st = STAT_NOTOWNER;
        end else if (!lk_q.claimed) begin
          lk_we         = 1'b1;
          lk_wd.claimed = 1'b1;
          lk_wd.owner   = p_idx;
        end else if (lk_q.owner == p_idx || (wt_q.busy && wt_q.lock == l_idx)) begin
          res_st = STAT_OK;
        end else if (wt_q.busy) begin
          res_st = STAT_FULL;
        end else begin
          res_st         = STAT_BLOCKED;
          lk_we          = 1'b1;
          lk_wd.tail     = p_idx;
          lk_wd.nonempty = 1'b1;
          if (!lk_q.nonempty) lk_wd.head = p_idx;
          nx_we          = lk_q.nonempty;
          wt_we          = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (!lock_ok) begin
          res_st = STAT_NOLOCK;
        end else if (!proc_ok || !lk_q.claimed || lk_q.owner != p_idx) begin
          res_st = STAT_NOTOWNER;
        end else if (!lk_q.nonempty) begin
          lk_we         = 1'b1;
          lk_wd.claimed = 1'b0;
          lk_wd.owner   = '0;
        end else begin
          lk_we       = 1'b1;
          lk_wd.owner = lk_q.head;
          if (lk_q.tail == lk_q.head) begin
            lk_wd.nonempty = 1'b0;
          end else begin
            need_fetch = 1'b1;
            lk_wd.head = nx_q;
          end
          wt_we  = 1'b1;
          wt_wa  = lk_q.head;
          wt_wd  = '0;
          res_wv = 1'b1;
          res_wp = lk_q.head;
        end
      end
      default: res_st = STAT_NOLOCK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && lk_we) lock_mem[lk_wa] <= lk_wd;
    if (cmd_i.load) lk_q <= lock_mem[LW'(lock_id_i)];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      wait_mem[clr_q] <= '0;
    end else if (cmd_i.commit && wt_we) begin
      wait_mem[wt_wa] <= wt_wd;
    end
    if (cmd_i.load) wt_q <= wait_mem[PW'(proc_id_i)];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && nx_we) next_mem[nx_wa] <= nx_wd;
    if (cmd_i.fetch) nx_q <= next_mem[lk_q.head];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      lid_q <= lock_id_i;
      pid_q <= proc_id_i;
    end
    if (cmd_i.commit) begin
      status_q <= res_st;
      nid_q    <= res_nid;
      woken_q  <= res_wv;
      wproc_q  <= 8'(res_wp);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + 1'b1;
      if (cmd_i.commit && free_inc) free_q <= free_q + 1'b1;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clear_done = clr_q == PW'(NUM_PROCS - 1);
  assign sts_o.need_fetch = need_fetch;
  assign sts_o.res_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign new_lock_id_o = nid_q;
  assign woken_valid_o = woken_q;
  assign woken_proc_o  = wproc_q;

  `MLTF_NEVER(a_commit_over_result, cmd_i.commit && out_valid_q && !out_ready_i, "result overwritten")
  `MLTF_ASSERT(a_free_bound, 32'(free_q) <= NUM_LOCKS, "lock count beyond table size")
  `MLTF_ASSERT(a_woken_ok, out_valid_q && woken_q |-> status_q == STAT_OK, "hand-off with error status")
  `MLTF_ASSERT(a_result_from_commit, $rose(out_valid_q) |-> $past(cmd_i.commit), "result without commit")

endmodule
